FILE: rtl/mots_pkg.sv
// -----------------------------------------------------------------------------
// Median of two sorted arrays: shared package
// Sizes, payload types and the control records passed between the units.
// -----------------------------------------------------------------------------
package mots_pkg;

   // Number of elements that each array can hold.
   localparam int unsigned DEPTH = 1024;

   // Address width of one store and width of an element count (0..DEPTH).
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

   // Element and result widths.
   localparam int unsigned ELEM_W = 32;
   localparam int unsigned MED_W  = 33;

   // Array selector codes.
   localparam logic SEL_FIRST  = 1'b0;
   localparam logic SEL_SECOND = 1'b1;

   // One input item.
   typedef struct packed {
      logic signed [ELEM_W-1:0] element_value;
      logic                     func;
      logic                     carries_element;
      logic                     last_item;
   } req_type;

   // One result item.
   typedef struct packed {
      logic signed [MED_W-1:0] median_doubled;
      logic                    both_empty;
      logic                    overflowed;
   } rsp_type;

   // Request to start a merge walk over the loaded elements.
   typedef struct packed {
      logic             valid;
      logic [CNT_W-1:0] first_count;
      logic [CNT_W-1:0] second_count;
   } walk_start_type;

   // Completion of a merge walk.
   typedef struct packed {
      logic                    done;
      logic signed [MED_W-1:0] median_doubled;
   } walk_result_type;

endpackage

FILE: rtl/mots_store.sv
// -----------------------------------------------------------------------------
// Element store
// Single-port-write, single-port-read synchronous memory with registered read
// data and write-to-read forwarding for a read of the entry being written.
// -----------------------------------------------------------------------------
module mots_store (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [mots_pkg::ADDR_W-1:0]      wr_addr,
   input  logic [mots_pkg::ELEM_W-1:0]      wr_data,
   input  logic [mots_pkg::ADDR_W-1:0]      rd_addr,
   output logic [mots_pkg::ELEM_W-1:0]      rd_data
);

   logic [mots_pkg::ELEM_W-1:0] mem_ff [mots_pkg::DEPTH];
   logic [mots_pkg::ELEM_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; a read of the entry written in the same cycle sees the new data.
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/mots_walk.sv
// -----------------------------------------------------------------------------
// Merge walker
// Walks both stores in ascending merge order, one element per cycle up to the
// upper middle, which waits for a free output, and sums the two middle elements.
// -----------------------------------------------------------------------------
module mots_walk (
   input  logic                                clock,
   input  logic                                reset,
   input  mots_pkg::walk_start_type            start,
   input  logic                                out_free,
   input  logic [mots_pkg::ELEM_W-1:0]         first_q,
   input  logic [mots_pkg::ELEM_W-1:0]         second_q,
   output logic [mots_pkg::ADDR_W-1:0]         first_rd_addr,
   output logic [mots_pkg::ADDR_W-1:0]         second_rd_addr,
   output logic                                busy,
   output mots_pkg::walk_result_type           result
);

   typedef enum logic {
      IDLE,
      WALK
   } state_type;

   state_type                   state_ff, state_in;
   logic [mots_pkg::CNT_W-1:0]  i_ff, i_in;
   logic [mots_pkg::CNT_W-1:0]  j_ff, j_in;
   logic [mots_pkg::CNT_W-1:0]  k_ff, k_in;
   logic [mots_pkg::CNT_W-1:0]  m_ff, m_in;
   logic [mots_pkg::CNT_W-1:0]  n_ff, n_in;
   logic [mots_pkg::CNT_W-1:0]  lo_ff, lo_in;
   logic [mots_pkg::CNT_W-1:0]  hi_ff, hi_in;
   logic [mots_pkg::ELEM_W-1:0] lo_val_ff, lo_val_in;

   logic [mots_pkg::CNT_W:0]    total;
   logic [mots_pkg::CNT_W:0]    total_less;
   logic                        take_first;
   logic [mots_pkg::ELEM_W-1:0] cur;
   logic [mots_pkg::ELEM_W-1:0] lo_sel;
   logic                        last_step;
   logic                        advance;

   // Position bounds of the two middle elements.
   assign total      = {1'b0, start.first_count} + {1'b0, start.second_count};
   assign total_less = total - {{mots_pkg::CNT_W{1'b0}}, 1'b1};

   // Head selection; a tie goes to the first array.
   always_comb begin
      priority if (i_ff >= m_ff) begin
         take_first = 1'b0;
      end else if (j_ff >= n_ff) begin
         take_first = 1'b1;
      end else begin
         take_first = ($signed(first_q) <= $signed(second_q));
      end
   end

   assign cur       = take_first ? first_q : second_q;
   assign last_step = (k_ff == hi_ff);
   assign advance   = (state_ff == WALK) && (!last_step || out_free);
   assign lo_sel    = (k_ff == lo_ff) ? cur : lo_val_ff;

   // Next-state logic.
   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      m_in      = m_ff;
      n_in      = n_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      lo_val_in = lo_val_ff;
      unique case (state_ff)
         IDLE: begin
            i_in = '0;
            j_in = '0;
            k_in = '0;
            if (start.valid) begin
               state_in = WALK;
               m_in     = start.first_count;
               n_in     = start.second_count;
               hi_in    = total[mots_pkg::CNT_W:1];
               lo_in    = total_less[mots_pkg::CNT_W:1];
            end
         end
         WALK: begin
            if (advance) begin
               if (k_ff == lo_ff) begin
                  lo_val_in = cur;
               end
               if (last_step) begin
                  state_in = IDLE;
                  i_in     = '0;
                  j_in     = '0;
                  k_in     = '0;
               end else begin
                  k_in = k_ff + 1'b1;
                  if (take_first) begin
                     i_in = i_ff + 1'b1;
                  end else begin
                     j_in = j_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // State and walk registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
      m_ff      <= m_in;
      n_ff      <= n_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      lo_val_ff <= lo_val_in;
   end

   // Reads follow the next pointers so that the read data matches the heads.
   assign first_rd_addr  = i_in[mots_pkg::ADDR_W-1:0];
   assign second_rd_addr = j_in[mots_pkg::ADDR_W-1:0];

   assign busy                  = (state_ff == WALK);
   assign result.done           = advance && last_step;
   assign result.median_doubled = {lo_sel[mots_pkg::ELEM_W-1], lo_sel}
                                + {cur[mots_pkg::ELEM_W-1], cur};

endmodule

FILE: rtl/median_of_two_sorted_arrays_top.sv
// -----------------------------------------------------------------------------
// Median of two sorted arrays
// Loads two ascending arrays into element stores and, on the last item of a
// batch, walks them in merge order to report twice the median of their union.
// -----------------------------------------------------------------------------
//   Channel   Ports                                Direction   Content
//   req       req_valid, req_stall, req_data       in          one element
//   rsp       rsp_valid, rsp_stall, rsp_data       out         one result
//
// Elements load at one transfer per cycle while req_stall is low. A last item
// with a non-empty batch starts a merge walk, one store read per array
// per cycle, during which req_stall is high; the result then sits in the output
// register. An empty batch gives its result in the cycle after its transfer.
// Reset clears counts, overflow, valid and walk state; the stores need no clearing pass.
// A last item is stalled while a result still waits and rsp_stall is high.
// -----------------------------------------------------------------------------
module median_of_two_sorted_arrays_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mots_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mots_pkg::rsp_type rsp_data
);

   logic [mots_pkg::CNT_W-1:0]  first_count_ff, first_count_in;
   logic [mots_pkg::CNT_W-1:0]  second_count_ff, second_count_in;
   logic                        overflow_ff, overflow_in;
   logic                        pend_overflow_ff, pend_overflow_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   mots_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   logic                        accept;
   logic                        out_free;
   logic                        walk_busy;
   logic                        first_full;
   logic                        second_full;
   logic                        wr_first;
   logic                        wr_second;
   logic                        drop;
   logic [mots_pkg::CNT_W-1:0]  first_next;
   logic [mots_pkg::CNT_W-1:0]  second_next;
   logic                        batch_overflow;
   logic                        batch_empty;

   logic [mots_pkg::ADDR_W-1:0] first_rd_addr;
   logic [mots_pkg::ADDR_W-1:0] second_rd_addr;
   logic [mots_pkg::ELEM_W-1:0] first_q;
   logic [mots_pkg::ELEM_W-1:0] second_q;
   mots_pkg::walk_start_type    walk_start;
   mots_pkg::walk_result_type   walk_result;

   // Handshake.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = walk_busy || (req_data.last_item && !out_free);
   assign accept    = req_valid && !req_stall;

   // Append logic; an element for a full array is dropped and flagged.
   assign first_full  = (first_count_ff == mots_pkg::CNT_W'(mots_pkg::DEPTH));
   assign second_full = (second_count_ff == mots_pkg::CNT_W'(mots_pkg::DEPTH));
   assign wr_first    = accept && req_data.carries_element
                     && (req_data.func == mots_pkg::SEL_FIRST) && !first_full;
   assign wr_second   = accept && req_data.carries_element
                     && (req_data.func == mots_pkg::SEL_SECOND) && !second_full;
   assign drop        = accept && req_data.carries_element && !wr_first && !wr_second;

   assign first_next     = first_count_ff + mots_pkg::CNT_W'(wr_first);
   assign second_next    = second_count_ff + mots_pkg::CNT_W'(wr_second);
   assign batch_overflow = overflow_ff || drop;
   assign batch_empty    = (first_next == '0) && (second_next == '0);

   // Walk request for a non-empty batch.
   assign walk_start.valid        = accept && req_data.last_item && !batch_empty;
   assign walk_start.first_count  = first_next;
   assign walk_start.second_count = second_next;

   // Batch bookkeeping and output register.
   always_comb begin
      first_count_in   = first_next;
      second_count_in  = second_next;
      overflow_in      = batch_overflow;
      pend_overflow_in = pend_overflow_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_data_in      = rsp_data_ff;
      if (accept && req_data.last_item) begin
         first_count_in   = '0;
         second_count_in  = '0;
         overflow_in      = 1'b0;
         pend_overflow_in = batch_overflow;
         if (batch_empty) begin
            rsp_valid_in               = 1'b1;
            rsp_data_in.median_doubled = '0;
            rsp_data_in.both_empty     = 1'b1;
            rsp_data_in.overflowed     = batch_overflow;
         end
      end
      if (walk_result.done) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.median_doubled = walk_result.median_doubled;
         rsp_data_in.both_empty     = 1'b0;
         rsp_data_in.overflowed     = pend_overflow_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_count_ff  <= '0;
         second_count_ff <= '0;
         overflow_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         overflow_ff     <= overflow_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      pend_overflow_ff <= pend_overflow_in;
      rsp_data_ff      <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Element stores.
   mots_store u_first_store (
      .clock   (clock),
      .wr_en   (wr_first),
      .wr_addr (first_count_ff[mots_pkg::ADDR_W-1:0]),
      .wr_data (req_data.element_value),
      .rd_addr (first_rd_addr),
      .rd_data (first_q)
   );

   mots_store u_second_store (
      .clock   (clock),
      .wr_en   (wr_second),
      .wr_addr (second_count_ff[mots_pkg::ADDR_W-1:0]),
      .wr_data (req_data.element_value),
      .rd_addr (second_rd_addr),
      .rd_data (second_q)
   );

   // Merge walker.
   mots_walk u_walk (
      .clock          (clock),
      .reset          (reset),
      .start          (walk_start),
      .out_free       (out_free),
      .first_q        (first_q),
      .second_q       (second_q),
      .first_rd_addr  (first_rd_addr),
      .second_rd_addr (second_rd_addr),
      .busy           (walk_busy),
      .result         (walk_result)
   );

endmodule
